@@ rtl/pa_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and codes of the page allocator
package pa_pkg;

  localparam int ADDR_W   = 27;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 3;
  localparam int REF_W    = 16;
  localparam int CFG_W    = 16;
  localparam int WIDE_W   = 32;

  localparam int PAGE_COUNT_DEF = 32768;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int COUNT_BITS_DEF = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC    = 3'd0,
    REQ_FREE     = 3'd1,
    REQ_ADD_REF  = 3'd2,
    REQ_DROP_REF = 3'd3,
    REQ_READ     = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_OOM     = 3'd1,
    ST_BADADDR = 3'd2,
    ST_UNDER   = 3'd3,
    ST_SAT     = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_CALC
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] page_address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_address;
    logic [REF_W-1:0]    share_count;
    logic                page_released;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } cnt_cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

endpackage

@@ rtl/pa_count_store.sv @@
`timescale 1ns / 1ps
// reference count memory with clearing sweep after reset
module pa_count_store #(
  parameter int PAGE_COUNT = pa_pkg::PAGE_COUNT_DEF,
  parameter int COUNT_BITS = pa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pa_pkg::cnt_cmd_t              cmd_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] rd_idx_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] wr_idx_i,
  input  logic [COUNT_BITS-1:0]         wr_cnt_i,
  output logic [COUNT_BITS-1:0]         rd_cnt_o,
  output logic                          busy_o
);

  localparam int IDX_W = $clog2(PAGE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGE_COUNT - 1);

  logic [COUNT_BITS-1:0] mem_q [PAGE_COUNT];
  logic [IDX_W-1:0]      clr_idx_q, clr_idx_d;
  logic                  busy_q, busy_d;
  logic                  we;
  logic [IDX_W-1:0]      w_idx;
  logic [COUNT_BITS-1:0] w_cnt;

  always_comb begin
    clr_idx_d = clr_idx_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_idx_d = clr_idx_q + IDX_W'(1);
      if (clr_idx_q == LAST_IDX) begin
        busy_d = 1'b0;
      end
    end
  end

  assign we    = busy_q || cmd_i.wr_en;
  assign w_idx = busy_q ? clr_idx_q : wr_idx_i;
  assign w_cnt = busy_q ? '0 : wr_cnt_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_idx_q <= clr_idx_d;
      busy_q    <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[w_idx] <= w_cnt;
    end
    if (cmd_i.rd_en) begin
      rd_cnt_o <= mem_q[rd_idx_i];
    end
  end

  assign busy_o = busy_q;

endmodule

@@ rtl/pa_free_stack.sv @@
`timescale 1ns / 1ps
// lifo memory of freed page indices with its depth pointer
module pa_free_stack #(
  parameter int PAGE_COUNT = pa_pkg::PAGE_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pa_pkg::stk_cmd_t              cmd_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] push_idx_i,
  output logic [$clog2(PAGE_COUNT)-1:0] top_idx_o,
  output pa_pkg::stk_stat_t             stat_o
);

  localparam int IDX_W   = $clog2(PAGE_COUNT);
  localparam int DEPTH_W = $clog2(PAGE_COUNT + 1);
  localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(PAGE_COUNT);

  logic [IDX_W-1:0]   mem_q [PAGE_COUNT];
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [DEPTH_W-1:0] top_ptr;

  assign top_ptr = depth_q - DEPTH_W'(1);

  always_comb begin
    depth_d = depth_q;
    if (cmd_i.push) begin
      depth_d = depth_q + DEPTH_W'(1);
    end else if (cmd_i.pop) begin
      depth_d = top_ptr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[depth_q[IDX_W-1:0]] <= push_idx_i;
    end
    if (cmd_i.pop) begin
      top_idx_o <= mem_q[top_ptr[IDX_W-1:0]];
    end
  end

  assign stat_o.empty = (depth_q == '0);
  assign stat_o.full  = (depth_q == FULL_DEPTH);

endmodule

@@ rtl/pa_ctrl.sv @@
`timescale 1ns / 1ps
// request sequencer, count update logic and result register
module pa_ctrl #(
  parameter int PAGE_COUNT = pa_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_SHIFT = pa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = pa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pa_pkg::in_item_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pa_pkg::out_item_t             out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pa_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                          cnt_busy_i,
  output pa_pkg::cnt_cmd_t              cnt_cmd_o,
  output logic [$clog2(PAGE_COUNT)-1:0] cnt_rd_idx_o,
  output logic [$clog2(PAGE_COUNT)-1:0] cnt_wr_idx_o,
  output logic [COUNT_BITS-1:0]         cnt_wr_o,
  input  logic [COUNT_BITS-1:0]         cnt_rd_i,
  output pa_pkg::stk_cmd_t              stk_cmd_o,
  output logic [$clog2(PAGE_COUNT)-1:0] stk_push_idx_o,
  input  logic [$clog2(PAGE_COUNT)-1:0] stk_top_i,
  input  pa_pkg::stk_stat_t             stk_stat_i
);

  localparam int IDX_W   = $clog2(PAGE_COUNT);
  localparam int DEPTH_W = $clog2(PAGE_COUNT + 1);
  localparam int PG_W    = pa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int ALLOC_W = IDX_W + PAGE_SHIFT;

  pa_pkg::state_e                state_q, state_d;
  logic [pa_pkg::REQ_W-1:0]      req_q, req_d;
  logic                          bad_q, bad_d;
  logic                          oom_q, oom_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [DEPTH_W-1:0]            fresh_q, fresh_d;
  logic [pa_pkg::CFG_W-1:0]      ffp_q;
  logic                          out_valid_q;
  pa_pkg::out_item_t             out_item_q, res;

  logic                          load;
  logic                          in_is_alloc;
  logic                          aligned, in_range, addr_ok, fresh_avail;
  logic [PG_W-1:0]               pg;
  logic [IDX_W-1:0]              addr_idx;
  logic [DEPTH_W-1:0]            fresh_dec;
  logic                          c_zero, c_one, c_max;
  logic [COUNT_BITS-1:0]         cnt_new;
  logic                          show_cnt, alloc_ok, wr_cnt, push;
  logic [pa_pkg::WIDE_W-1:0]     cnt_ext;
  logic [ALLOC_W-1:0]            alloc_full;

  // address decode of the incoming item
  assign pg          = in_item_i.page_address[pa_pkg::ADDR_W-1:PAGE_SHIFT];
  assign aligned     = (in_item_i.page_address[PAGE_SHIFT-1:0] == '0);
  assign in_range    = (pa_pkg::WIDE_W'(pg) >= pa_pkg::WIDE_W'(ffp_q))
                    && (pa_pkg::WIDE_W'(pg) < pa_pkg::WIDE_W'(PAGE_COUNT));
  assign addr_ok     = aligned && in_range;
  assign addr_idx    = IDX_W'(pg);
  assign fresh_dec   = fresh_q - DEPTH_W'(1);
  assign fresh_avail = pa_pkg::WIDE_W'(fresh_q) > pa_pkg::WIDE_W'(ffp_q);
  assign in_is_alloc = (in_item_i.req_type == pa_pkg::REQ_ALLOC);

  assign c_zero = (cnt_rd_i == '0);
  assign c_one  = (cnt_rd_i == COUNT_BITS'(1));
  assign c_max  = &cnt_rd_i;

  assign load = (state_q == pa_pkg::S_CALC) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pa_pkg::S_CLEAR: begin
        if (!cnt_busy_i) begin
          state_d = pa_pkg::S_IDLE;
        end
      end
      pa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_is_alloc && !stk_stat_i.empty) ? pa_pkg::S_POP : pa_pkg::S_CALC;
        end
      end
      pa_pkg::S_POP: begin
        state_d = pa_pkg::S_CALC;
      end
      pa_pkg::S_CALC: begin
        if (load) begin
          state_d = pa_pkg::S_IDLE;
        end
      end
      default: state_d = pa_pkg::S_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall_o = 1'b1;
    cnt_cmd_o  = '0;
    stk_cmd_o  = '0;
    req_d      = req_q;
    bad_d      = bad_q;
    oom_d      = oom_q;
    idx_d      = idx_q;
    fresh_d    = fresh_q;
    cnt_new    = cnt_rd_i;
    show_cnt   = 1'b0;
    alloc_ok   = 1'b0;
    wr_cnt     = 1'b0;
    push       = 1'b0;
    res        = '0;
    unique case (state_q)
      pa_pkg::S_CLEAR: begin
      end
      pa_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d = in_item_i.req_type;
          bad_d = 1'b0;
          oom_d = 1'b0;
          if (in_is_alloc) begin
            if (!stk_stat_i.empty) begin
              stk_cmd_o.pop = 1'b1;
            end else if (fresh_avail) begin
              fresh_d         = fresh_dec;
              idx_d           = fresh_dec[IDX_W-1:0];
              cnt_cmd_o.rd_en = 1'b1;
            end else begin
              oom_d = 1'b1;
            end
          end else if (in_item_i.req_type <= pa_pkg::REQ_READ) begin
            if (addr_ok) begin
              idx_d           = addr_idx;
              cnt_cmd_o.rd_en = 1'b1;
            end else begin
              bad_d = 1'b1;
            end
          end
        end
      end
      pa_pkg::S_POP: begin
        idx_d           = stk_top_i;
        cnt_cmd_o.rd_en = 1'b1;
      end
      pa_pkg::S_CALC: begin
        res.status = pa_pkg::ST_OK;
        priority if (bad_q) begin
          res.status = pa_pkg::ST_BADADDR;
        end else begin
          unique case (req_q)
            pa_pkg::REQ_ALLOC: begin
              if (oom_q) begin
                res.status = pa_pkg::ST_OOM;
              end else begin
                cnt_new  = c_max ? cnt_rd_i : cnt_rd_i + COUNT_BITS'(1);
                wr_cnt   = 1'b1;
                show_cnt = 1'b1;
                alloc_ok = 1'b1;
              end
            end
            pa_pkg::REQ_FREE: begin
              show_cnt = 1'b1;
              if (c_zero) begin
                res.status = pa_pkg::ST_UNDER;
              end else if (c_one) begin
                if (stk_stat_i.full) begin
                  res.status = pa_pkg::ST_FULL;
                end else begin
                  cnt_new           = '0;
                  wr_cnt            = 1'b1;
                  push              = 1'b1;
                  res.page_released = 1'b1;
                end
              end else begin
                cnt_new = cnt_rd_i - COUNT_BITS'(1);
                wr_cnt  = 1'b1;
              end
            end
            pa_pkg::REQ_ADD_REF: begin
              show_cnt = 1'b1;
              if (c_max) begin
                res.status = pa_pkg::ST_SAT;
              end else begin
                cnt_new = cnt_rd_i + COUNT_BITS'(1);
                wr_cnt  = 1'b1;
              end
            end
            pa_pkg::REQ_DROP_REF: begin
              show_cnt = 1'b1;
              if (c_zero) begin
                res.status = pa_pkg::ST_UNDER;
              end else begin
                cnt_new = cnt_rd_i - COUNT_BITS'(1);
                wr_cnt  = 1'b1;
              end
            end
            pa_pkg::REQ_READ: begin
              show_cnt = 1'b1;
            end
            default: begin
            end
          endcase
        end
        res.share_count   = show_cnt ? cnt_ext[pa_pkg::REF_W-1:0] : '0;
        res.alloc_address = alloc_ok ? pa_pkg::ADDR_W'(alloc_full) : '0;
        cnt_cmd_o.wr_en   = load && wr_cnt;
        stk_cmd_o.push    = load && push;
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext    = pa_pkg::WIDE_W'(cnt_new);
  assign alloc_full = {idx_q, {PAGE_SHIFT{1'b0}}};

  assign cnt_rd_idx_o   = idx_d;
  assign cnt_wr_idx_o   = idx_q;
  assign cnt_wr_o       = cnt_new;
  assign stk_push_idx_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pa_pkg::S_CLEAR;
      fresh_q     <= DEPTH_W'(PAGE_COUNT);
      ffp_q       <= '0;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      bad_q       <= 1'b0;
      oom_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      fresh_q <= fresh_d;
      req_q   <= req_d;
      bad_q   <= bad_d;
      oom_q   <= oom_d;
      if (cfg_valid_i) begin
        ffp_q <= cfg_data_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (load) begin
      out_item_q <= res;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/page_allocator_with_refcount_top.sv @@
`timescale 1ns / 1ps
// top level of the page allocator with reference counts
//
//  port group    dir  handshake          carries
//  in_*          in   valid / stall      in_item_t: req_type, page_address
//  out_*         out  valid / stall      out_item_t: status, alloc_address,
//                                        share_count, page_released
//  cfg_*         in   valid / ready      first_free_page write data
//
//  an item reads the count memory when accepted, then updates it and loads
//  the result register in S_CALC; an allocate served from the freed list
//  reads the stack memory first, so its count memory read comes in S_POP
//  after reset a clearing pass zeroes the count memory; in_stall_o stays
//  high until the sequencer leaves S_CLEAR; cfg writes are taken throughout
//  a stalled result holds the block in its update cycle until it is taken
module page_allocator_with_refcount_top #(
  parameter int PAGE_COUNT = pa_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_SHIFT = pa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = pa_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  pa_pkg::in_item_t         in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output pa_pkg::out_item_t        out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [pa_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(PAGE_COUNT);

  pa_pkg::cnt_cmd_t      cnt_cmd;
  logic [IDX_W-1:0]      cnt_rd_idx, cnt_wr_idx;
  logic [COUNT_BITS-1:0] cnt_wr, cnt_rd;
  logic                  cnt_busy;
  pa_pkg::stk_cmd_t      stk_cmd;
  pa_pkg::stk_stat_t     stk_stat;
  logic [IDX_W-1:0]      stk_push_idx, stk_top;

  pa_count_store #(
    .PAGE_COUNT(PAGE_COUNT),
    .COUNT_BITS(COUNT_BITS)
  ) u_count_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cnt_cmd),
    .rd_idx_i (cnt_rd_idx),
    .wr_idx_i (cnt_wr_idx),
    .wr_cnt_i (cnt_wr),
    .rd_cnt_o (cnt_rd),
    .busy_o   (cnt_busy)
  );

  pa_free_stack #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_free_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (stk_cmd),
    .push_idx_i (stk_push_idx),
    .top_idx_o  (stk_top),
    .stat_o     (stk_stat)
  );

  pa_ctrl #(
    .PAGE_COUNT(PAGE_COUNT),
    .PAGE_SHIFT(PAGE_SHIFT),
    .COUNT_BITS(COUNT_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_item_i      (in_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_o     (out_item_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cnt_busy_i     (cnt_busy),
    .cnt_cmd_o      (cnt_cmd),
    .cnt_rd_idx_o   (cnt_rd_idx),
    .cnt_wr_idx_o   (cnt_wr_idx),
    .cnt_wr_o       (cnt_wr),
    .cnt_rd_i       (cnt_rd),
    .stk_cmd_o      (stk_cmd),
    .stk_push_idx_o (stk_push_idx),
    .stk_top_i      (stk_top),
    .stk_stat_i     (stk_stat)
  );

  // no pop from an empty list, no push onto a full one
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_cmd.pop |-> !stk_stat.empty)
    else $error("pop from empty free list");

  a_push_nonfull : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_cmd.push |-> !stk_stat.full)
    else $error("push onto full free list");

  // the clearing pass owns the count memory
  a_clear_owns_mem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_busy |-> (!cnt_cmd.rd_en && !cnt_cmd.wr_en && in_stall_o))
    else $error("count memory accessed during clearing pass");

  // one item in flight at a time
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while another is in flight");

endmodule
